>>> rtl/lobu_pkg.sv
// Shared types and codes for the limit order book update block.
// No dependencies.
package lobu_pkg;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_EXECUTE = 3'd1;
  localparam logic [2:0] REQ_CANCEL  = 3'd2;
  localparam logic [2:0] REQ_DELETE  = 3'd3;
  localparam logic [2:0] REQ_REPLACE = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_SHARES   = 3'd6;

  // Stored quantity and price widths (request fields are 32 bits wide)
  localparam int QTY_BITS   = 32;
  localparam int PRICE_BITS = 32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] ord_id;
    logic [63:0] repl_id;
    logic [63:0] symbol;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] price;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status;
    logic [31:0] remaining_quantity;
    logic        top_bid_valid;
    logic [31:0] top_bid;
    logic        top_ask_valid;
    logic [31:0] top_ask;
  } rsp_t;

  // Scan modes driven by the controller.
  localparam logic [1:0] SCAN_FIND = 2'd0;  // id match, free slot, level total
  localparam logic [1:0] SCAN_NEW  = 2'd1;  // second id lookup (replace new id)
  localparam logic [1:0] SCAN_BEST = 2'd2;  // best bid/ask of the symbol

  typedef struct packed {
    logic       scan_start;
    logic [1:0] scan_mode;
    logic       decide;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic clearing;
  } sts_t;

endpackage

>>> rtl/lobu_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module lobu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/lobu_datapath.sv
// Order table datapath: entry RAM with live flags, sequential scans and decision.
// Depends on lobu_pkg and lobu_ram.
module lobu_datapath #(
  parameter int BOOK_SLOTS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  lobu_pkg::req_t  req,
  input  lobu_pkg::cmd_t  cmd,
  output lobu_pkg::sts_t  sts,
  output lobu_pkg::rsp_t  rsp
);
  localparam int QTY_BITS   = lobu_pkg::QTY_BITS;
  localparam int PRICE_BITS = lobu_pkg::PRICE_BITS;
  localparam int AW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam int CW = $clog2(BOOK_SLOTS + 1);
  localparam int EW = 1 + 64 + 64 + 1 + QTY_BITS + PRICE_BITS;
  localparam logic [QTY_BITS:0] QMAX = {1'b0, {QTY_BITS{1'b1}}};

  typedef struct packed {
    logic                  live;
    logic [63:0]           id;
    logic [63:0]           sym;
    logic                  side;
    logic [QTY_BITS-1:0]   qty;
    logic [PRICE_BITS-1:0] price;
  } ent_t;

  // Request registers
  lobu_pkg::req_t        req_r;
  logic [QTY_BITS-1:0]   qty_in;
  logic [PRICE_BITS-1:0] price_in;
  assign qty_in   = req_r.quantity[QTY_BITS-1:0];
  assign price_in = req_r.price[PRICE_BITS-1:0];

  // Clearing pass after reset
  logic          clr_act_r, clr_act_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;

  // Scan pipeline: address issue, then data + index registered in the next cycle
  logic          scan_act_r, scan_act_nxt;
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          chk_r;
  logic [AW-1:0] chk_idx_r;
  logic [1:0]    mode_r;
  logic [AW-1:0] raddr;
  ent_t          rd;

  // Scan results
  logic                  hit_r;
  logic [AW-1:0]         hit_idx_r;
  ent_t                  hit_ent_r;
  logic                  nhit_r;
  logic                  free_v_r;
  logic [AW-1:0]         free_idx_r;
  logic [QTY_BITS:0]     total_r;  // saturating level total
  logic                  bidv_r, askv_r;
  logic [PRICE_BITS-1:0] bid_r, ask_r;

  // Decision registers
  logic [2:0]            st_r;
  logic [QTY_BITS-1:0]   rem_r;
  logic [63:0]           sym_r;

  // Writes
  logic                  we;
  logic [AW-1:0]         waddr;
  ent_t                  wdata;

  assign raddr = scan_cnt_r[AW-1:0];

  lobu_ram #(.WIDTH(EW), .DEPTH(BOOK_SLOTS)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd)
  );

  // Clear counter: one entry per cycle
  always_comb begin
    clr_act_nxt = clr_act_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_act_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(BOOK_SLOTS - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  // Scan counter
  always_comb begin
    scan_act_nxt = scan_act_r;
    scan_cnt_nxt = scan_cnt_r;
    if (cmd.scan_start) begin
      scan_act_nxt = 1'b1;
      scan_cnt_nxt = '0;
    end else if (scan_act_r) begin
      if (scan_cnt_r == CW'(BOOK_SLOTS - 1)) begin
        scan_act_nxt = 1'b0;
      end
      scan_cnt_nxt = scan_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      scan_cnt_r <= '0;
      chk_r      <= 1'b0;
      clr_act_r  <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      scan_act_r <= scan_act_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      chk_r      <= scan_act_r;
      clr_act_r  <= clr_act_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  assign sts.scan_done = chk_r && !scan_act_r;
  assign sts.clearing  = clr_act_r;

  // Per-entry evaluation of the registered read
  logic          e_live;
  logic [QTY_BITS:0] sum;
  assign e_live = rd.live;
  assign sum = total_r + {1'b0, rd.qty};

  always_ff @(posedge clk) begin
    chk_idx_r <= raddr;
    if (load) begin
      req_r <= req;
    end
    if (cmd.scan_start) begin
      mode_r <= cmd.scan_mode;
      if (cmd.scan_mode == lobu_pkg::SCAN_FIND) begin
        hit_r    <= 1'b0;
        free_v_r <= 1'b0;
        total_r  <= '0;
      end else if (cmd.scan_mode == lobu_pkg::SCAN_NEW) begin
        nhit_r <= 1'b0;
      end else begin
        bidv_r <= 1'b0;
        askv_r <= 1'b0;
        bid_r  <= '0;
        ask_r  <= '0;
      end
    end else if (chk_r) begin
      unique case (mode_r)
        lobu_pkg::SCAN_FIND: begin
          if (e_live && rd.id == req_r.ord_id && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= chk_idx_r;
            hit_ent_r <= rd;
          end
          if (!e_live && !free_v_r) begin
            free_v_r   <= 1'b1;
            free_idx_r <= chk_idx_r;
          end
          if (e_live && rd.sym == req_r.symbol && rd.side == req_r.side &&
              rd.price == price_in) begin
            total_r <= (sum > QMAX) ? QMAX + (QTY_BITS+1)'(1) : sum;
          end
        end
        lobu_pkg::SCAN_NEW: begin
          // level total here is for the stored symbol/side, old entry excluded
          if (e_live && rd.id == req_r.repl_id) begin
            nhit_r <= 1'b1;
          end
          if (e_live && rd.sym == hit_ent_r.sym && rd.side == hit_ent_r.side &&
              rd.price == price_in && chk_idx_r != hit_idx_r) begin
            total_r <= (sum > QMAX) ? QMAX + (QTY_BITS+1)'(1) : sum;
          end
        end
        default: begin
          if (e_live && rd.sym == sym_r) begin
            if (rd.side == 1'b0) begin
              if (!bidv_r || rd.price > bid_r) bid_r <= rd.price;
              bidv_r <= 1'b1;
            end else begin
              if (!askv_r || rd.price < ask_r) ask_r <= rd.price;
              askv_r <= 1'b1;
            end
          end
        end
      endcase
    end
    // Before the replace lookup the level total restarts.
    if (cmd.scan_start && cmd.scan_mode == lobu_pkg::SCAN_NEW) begin
      total_r <= '0;
    end
  end

  // Decision: status, remaining quantity, table update
  logic [2:0]          st_d;
  logic [QTY_BITS-1:0] rem_d;
  logic [QTY_BITS-1:0] left;
  logic                ovf;
  logic                free_ok;
  assign left = hit_ent_r.qty - qty_in;
  assign ovf  = (total_r > QMAX) || ((QMAX - total_r) < {1'b0, qty_in});
  assign free_ok = free_v_r;

  always_comb begin
    st_d     = lobu_pkg::ST_OK;
    rem_d    = '0;
    we       = 1'b0;
    waddr    = free_idx_r;
    wdata    = '{live: 1'b1, id: req_r.ord_id, sym: req_r.symbol, side: req_r.side,
                 qty: qty_in, price: price_in};
    if (cmd.commit) begin
      unique case (req_r.req_type)
        lobu_pkg::REQ_ADD: begin
          if (req_r.ord_id == '0 || qty_in == '0) st_d = lobu_pkg::ST_ZERO;
          else if (hit_r) st_d = lobu_pkg::ST_DUP;
          else if (!free_ok) st_d = lobu_pkg::ST_FULL;
          else if (ovf) st_d = lobu_pkg::ST_OVERFLOW;
          else begin
            we = 1'b1;
            rem_d = qty_in;
          end
        end
        lobu_pkg::REQ_EXECUTE, lobu_pkg::REQ_CANCEL: begin
          if (!hit_r) st_d = lobu_pkg::ST_UNKNOWN;
          else if (qty_in == '0) st_d = lobu_pkg::ST_ZERO;
          else if (qty_in > hit_ent_r.qty) st_d = lobu_pkg::ST_SHARES;
          else begin
            we    = 1'b1;
            waddr = hit_idx_r;
            wdata = hit_ent_r;
            wdata.qty  = left;
            wdata.live = (left != '0);
            rem_d = left;
          end
        end
        lobu_pkg::REQ_DELETE: begin
          if (!hit_r) st_d = lobu_pkg::ST_UNKNOWN;
          else begin
            we    = 1'b1;
            waddr = hit_idx_r;
            wdata = hit_ent_r;
            wdata.live = 1'b0;
          end
        end
        lobu_pkg::REQ_REPLACE: begin
          if (!hit_r) st_d = lobu_pkg::ST_UNKNOWN;
          else if (req_r.repl_id == '0 || qty_in == '0) st_d = lobu_pkg::ST_ZERO;
          else if (nhit_r) st_d = lobu_pkg::ST_DUP;
          else begin
            // new order reuses the old slot; the old one is gone either way
            we    = 1'b1;
            waddr = hit_idx_r;
            if (ovf) begin
              st_d  = lobu_pkg::ST_OVERFLOW;
              wdata = hit_ent_r;
              wdata.live = 1'b0;
            end else begin
              wdata = '{live: 1'b1, id: req_r.repl_id, sym: hit_ent_r.sym,
                        side: hit_ent_r.side, qty: qty_in, price: price_in};
              rem_d = qty_in;
            end
          end
        end
        default: st_d = lobu_pkg::ST_ZERO;
      endcase
    end
    // Clearing pass owns the write port after reset
    if (clr_act_r) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_r  <= st_d;
      rem_r <= rem_d;
    end
    if (cmd.decide) begin
      if (req_r.req_type != lobu_pkg::REQ_ADD && hit_r &&
          req_r.req_type <= lobu_pkg::REQ_REPLACE) begin
        sym_r <= hit_ent_r.sym;
      end else begin
        sym_r <= req_r.symbol;
      end
    end
  end

  always_comb begin
    rsp.accepted           = (st_r == lobu_pkg::ST_OK);
    rsp.status             = st_r;
    rsp.remaining_quantity = 32'(rem_r);
    rsp.top_bid_valid      = bidv_r;
    rsp.top_bid            = 32'(bid_r);
    rsp.top_ask_valid      = askv_r;
    rsp.top_ask            = 32'(ask_r);
  end

  always_ff @(posedge clk) begin
    if (rst_n && chk_r && mode_r == lobu_pkg::SCAN_BEST && !scan_act_r)
      assert (!(bidv_r === 1'bx)) else $error("bid flag unknown");
  end

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |=> !sts.scan_done) else $error("scan done held");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !scan_act_r) else $error("commit during scan");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !scan_act_r && !chk_r) else $error("scan overlap");
endmodule

>>> rtl/lobu_ctrl.sv
// Controller for the order book: sequences scans, decision and result handoff.
// Depends on lobu_pkg.
module lobu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [2:0]     req_type,
  output logic           load,
  output lobu_pkg::cmd_t cmd,
  input  lobu_pkg::sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_NEW  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_BEST = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       start_r, start_nxt;

  assign in_ready  = (state_r == S_IDLE) && !sts.clearing;
  assign out_valid = (state_r == S_OUT);
  assign load      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    cmd       = '0;
    cmd.scan_start = start_r;
    unique case (state_r)
      S_IDLE: if (load) begin
        state_nxt = S_FIND;
        start_nxt = 1'b1;
      end
      S_FIND: begin
        cmd.scan_mode = lobu_pkg::SCAN_FIND;
        if (sts.scan_done) begin
          if (req_type == lobu_pkg::REQ_REPLACE) begin
            state_nxt = S_NEW;
            start_nxt = 1'b1;
          end else state_nxt = S_DEC;
        end
      end
      S_NEW: begin
        cmd.scan_mode = lobu_pkg::SCAN_NEW;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = S_BEST;
        start_nxt  = 1'b1;
      end
      S_BEST: begin
        cmd.scan_mode = lobu_pkg::SCAN_BEST;
        if (sts.scan_done) state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit) else $error("double commit");
endmodule

>>> rtl/limit_order_book_update.sv
// Top level of the limit order book update block: controller plus datapath.
// Depends on lobu_pkg, lobu_ctrl, lobu_datapath, lobu_ram.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_req  (lobu_pkg::req_t)
//  out     | out_valid / out_ready| out_rsp (lobu_pkg::rsp_t)
//
// One request at a time: a full pass over the single-read-port order table RAM
// looks up the order id (a replace adds a second pass for the new id), the table
// is updated, and a last pass finds the best bid and ask of the symbol; a new
// request is taken only after the result has been accepted with out_ready.
// Reset is synchronous, active low; a clearing pass then writes every table
// entry empty, with in_ready low.
// The result is held until out_ready; the next request is taken after that.
module limit_order_book_update #(
  parameter int BOOK_SLOTS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lobu_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output lobu_pkg::rsp_t out_rsp
);
  logic           load;
  lobu_pkg::cmd_t cmd;
  lobu_pkg::sts_t sts;
  lobu_pkg::req_t cur_r;

  always_ff @(posedge clk) begin
    if (load) cur_r <= in_req;
  end

  lobu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .req_type(cur_r.req_type),
    .load(load), .cmd(cmd), .sts(sts)
  );

  lobu_datapath #(
    .BOOK_SLOTS(BOOK_SLOTS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .load(load), .req(in_req),
    .cmd(cmd), .sts(sts), .rsp(out_rsp)
  );
endmodule

>>> verif/limit_order_book_update_tb.sv
// Testbench for limit_order_book_update: random and directed order book events
// checked against a behavioral order table. Depends on lobu_pkg and the RTL.
`timescale 1ns / 100ps

module limit_order_book_update_tb;

  localparam int BOOK_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int N_RANDOM = 555;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lobu_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lobu_pkg::rsp_t out_rsp;

  limit_order_book_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow order table
  bit          book_live [BOOK_DEPTH];
  logic [63:0] book_id   [BOOK_DEPTH];
  logic [63:0] book_sym  [BOOK_DEPTH];
  logic        book_side [BOOK_DEPTH];
  logic [31:0] book_qty  [BOOK_DEPTH];
  logic [31:0] book_px   [BOOK_DEPTH];

  lobu_pkg::req_t pending_reqs[$];
  lobu_pkg::rsp_t expected_rsps[$];
  int   mismatches = 0;
  bit   timed_out = 0;
  bit   drain_hold = 0;
  int   idle_cycles = 0;

  function automatic int find_order(logic [63:0] id);
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (book_live[i] && book_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [2:0] insert_order(logic [63:0] id, logic [63:0] sym,
                                              logic sd, logic [31:0] qty,
                                              logic [31:0] px);
    logic [63:0] total;
    int slot;
    total = 0;
    slot = -1;
    if (find_order(id) >= 0) return lobu_pkg::ST_DUP;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (!book_live[i] && slot < 0) slot = i;
    if (slot < 0) return lobu_pkg::ST_FULL;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (book_live[i] && book_sym[i] == sym && book_side[i] == sd && book_px[i] == px)
        total += book_qty[i];
    if (total + qty > 64'hFFFF_FFFF) return lobu_pkg::ST_OVERFLOW;
    book_live[slot] = 1;
    book_id[slot] = id;
    book_sym[slot] = sym;
    book_side[slot] = sd;
    book_qty[slot] = qty;
    book_px[slot] = px;
    return lobu_pkg::ST_OK;
  endfunction

  // Apply one event to the shadow table and return the expected response
  function automatic lobu_pkg::rsp_t apply_event(lobu_pkg::req_t r);
    lobu_pkg::rsp_t rs;
    logic [2:0] st;
    logic [63:0] sym;
    logic [31:0] rem;
    int k;
    rs = '0;
    st = lobu_pkg::ST_OK;
    rem = 0;
    sym = r.symbol;
    case (r.req_type)
      lobu_pkg::REQ_ADD: begin
        if (r.ord_id == 0 || r.quantity == 0) st = lobu_pkg::ST_ZERO;
        else begin
          st = insert_order(r.ord_id, r.symbol, r.side, r.quantity, r.price);
          rem = r.quantity;
        end
      end
      lobu_pkg::REQ_EXECUTE, lobu_pkg::REQ_CANCEL, lobu_pkg::REQ_DELETE,
      lobu_pkg::REQ_REPLACE: begin
        k = find_order(r.ord_id);
        if (k < 0) st = lobu_pkg::ST_UNKNOWN;
        else begin
          sym = book_sym[k];
          if (r.req_type == lobu_pkg::REQ_DELETE) begin
            book_live[k] = 0;
          end else if (r.req_type == lobu_pkg::REQ_REPLACE) begin
            if (r.repl_id == 0 || r.quantity == 0) st = lobu_pkg::ST_ZERO;
            else if (find_order(r.repl_id) >= 0) st = lobu_pkg::ST_DUP;
            else begin
              book_live[k] = 0;
              st = insert_order(r.repl_id, sym, book_side[k], r.quantity, r.price);
              rem = r.quantity;
            end
          end else begin
            if (r.quantity == 0) st = lobu_pkg::ST_ZERO;
            else if (r.quantity > book_qty[k]) st = lobu_pkg::ST_SHARES;
            else begin
              book_qty[k] -= r.quantity;
              rem = book_qty[k];
              if (rem == 0) book_live[k] = 0;
            end
          end
        end
      end
      default: st = lobu_pkg::ST_ZERO;
    endcase
    if (st != lobu_pkg::ST_OK) rem = 0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!book_live[i] || book_sym[i] != sym) continue;
      if (book_side[i] == 1'b0) begin
        if (!rs.top_bid_valid || book_px[i] > rs.top_bid) rs.top_bid = book_px[i];
        rs.top_bid_valid = 1;
      end else begin
        if (!rs.top_ask_valid || book_px[i] < rs.top_ask) rs.top_ask = book_px[i];
        rs.top_ask_valid = 1;
      end
    end
    rs.accepted = (st == lobu_pkg::ST_OK);
    rs.status = st;
    rs.remaining_quantity = rem;
    return rs;
  endfunction

  // Stimulus helpers; ids in use are tracked loosely to aim at live orders
  logic [63:0] used_ids[$];
  logic [63:0] symbols[4] = '{64'h0, 64'h4142_4344_0000_0000, 64'h5858_5858_5858_5858,
                              64'hFFFF_FFFF_FFFF_FFFF};

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 9) < 8)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    if ($urandom_range(0, 9) == 0) return 64'h0;
    return rand64();
  endfunction

  task automatic push_req(logic [2:0] kind, logic [63:0] oid, logic [63:0] nid,
                          logic [63:0] sym, logic sd, logic [31:0] qty, logic [31:0] px);
    lobu_pkg::req_t r;
    r.req_type = kind;
    r.ord_id = oid;
    r.repl_id = nid;
    r.symbol = sym;
    r.side = sd;
    r.quantity = qty;
    r.price = px;
    pending_reqs.insert(pending_reqs.size(), r);
    if (kind == lobu_pkg::REQ_ADD) used_ids.insert(used_ids.size(), oid);
    if (kind == lobu_pkg::REQ_REPLACE) used_ids.insert(used_ids.size(), nid);
  endtask

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic logic [31:0] rand_px();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(95, 105);
    endcase
  endfunction

  // Stimulus
  initial begin
    int kind;
    logic [63:0] oid;
    // directed part: extremes, every kind and each rejection except a full table
    push_req(lobu_pkg::REQ_ADD, 64'd1, 0, symbols[1], 0, 32'd100, 32'd50);
    push_req(lobu_pkg::REQ_ADD, 64'd2, 0, symbols[1], 1, 32'd10, 32'd60);
    push_req(lobu_pkg::REQ_ADD, 64'd1, 0, symbols[1], 0, 32'd5, 32'd55);  // duplicate
    push_req(lobu_pkg::REQ_ADD, 64'd0, 0, symbols[1], 0, 32'd5, 32'd55);  // zero id
    push_req(lobu_pkg::REQ_ADD, 64'd3, 0, symbols[1], 0, 32'd0, 32'd55);  // zero qty
    push_req(lobu_pkg::REQ_ADD, 64'd4, 0, symbols[1], 0, 32'hFFFF_FFFF,
             32'd50);                                                      // level overflow
    push_req(lobu_pkg::REQ_ADD, '1, 0, '1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(lobu_pkg::REQ_ADD, 64'd5, 0, '1, 0, 32'd1, 32'd0);
    push_req(lobu_pkg::REQ_EXECUTE, 64'd1, 0, 0, 0, 32'd30, 0);
    push_req(lobu_pkg::REQ_EXECUTE, 64'd1, 0, 0, 0, 32'd0, 0);            // zero shares
    push_req(lobu_pkg::REQ_CANCEL, 64'd1, 0, 0, 0, 32'd71, 0);            // too many shares
    push_req(lobu_pkg::REQ_CANCEL, 64'd1, 0, 0, 0, 32'd70, 0);            // fully removed
    push_req(lobu_pkg::REQ_EXECUTE, 64'd99, 0, symbols[1], 0, 32'd1, 0);  // unknown
    push_req(lobu_pkg::REQ_DELETE, 64'd2, 0, 0, 0, 0, 0);
    push_req(lobu_pkg::REQ_DELETE, 64'd2, 0, symbols[2], 0, 0, 0);        // unknown
    push_req(lobu_pkg::REQ_ADD, 64'd6, 0, symbols[2], 0, 32'd8, 32'd70);
    push_req(lobu_pkg::REQ_ADD, 64'd7, 0, symbols[2], 0, 32'd8, 32'd71);
    push_req(lobu_pkg::REQ_REPLACE, 64'd6, 64'd7, 0, 0, 32'd5, 32'd72);   // new id live
    push_req(lobu_pkg::REQ_REPLACE, 64'd6, 64'd6, 0, 0, 32'd5, 32'd72);   // own id
    push_req(lobu_pkg::REQ_REPLACE, 64'd6, 64'd0, 0, 0, 32'd5, 32'd72);   // zero new id
    push_req(lobu_pkg::REQ_REPLACE, 64'd6, 64'd8, 0, 0, 32'd5, 32'd73);
    // replace at the old order's price, whose quantity is left out of the level total
    push_req(lobu_pkg::REQ_REPLACE, '1, 64'd9, 0, 0, 32'd1, 32'hFFFF_FFFF);
    push_req(lobu_pkg::REQ_REPLACE, 64'd123, 64'd10, 0, 1, 32'd1, 32'd1); // unknown
    push_req(3'd5, 64'd8, 0, symbols[2], 0, 32'd1, 32'd1);
    push_req(3'd7, 64'd8, 0, symbols[2], 1, 32'd1, 32'd1);
    // random part, mostly well-formed against live ids
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 99);
      oid = pick_id();
      if (kind < 40)
        push_req(lobu_pkg::REQ_ADD, ($urandom_range(0, 9) == 0) ? oid : rand64(), rand64(),
                 ($urandom_range(0, 9) == 0) ? rand64() : symbols[$urandom_range(0, 3)],
                 $urandom_range(0, 1), rand_qty(), rand_px());
      else if (kind < 60)
        push_req(lobu_pkg::REQ_EXECUTE, oid, rand64(), rand64(), $urandom_range(0, 1),
                 rand_qty(), $urandom);
      else if (kind < 72)
        push_req(lobu_pkg::REQ_CANCEL, oid, rand64(), rand64(), $urandom_range(0, 1),
                 rand_qty(), $urandom);
      else if (kind < 82)
        push_req(lobu_pkg::REQ_DELETE, oid, rand64(), rand64(), $urandom_range(0, 1),
                 $urandom, $urandom);
      else if (kind < 97)
        push_req(lobu_pkg::REQ_REPLACE, oid,
                 ($urandom_range(0, 4) == 0) ? pick_id() : rand64(),
                 rand64(), $urandom_range(0, 1), rand_qty(), rand_px());
      else
        push_req(3'($urandom_range(5, 7)), oid, rand64(), rand64(), $urandom_range(0, 1),
                 $urandom, $urandom);
    end
  end

  // Reset
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Driver: bursts with gaps; once pauses until every outstanding response has come back
  int burst_left = 0;
  int gap_left = 0;
  int sent = 0;
  bit in_fire_q = 1'b0;

  always @(posedge clk) begin
    in_fire_q <= rst_n && in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire_q)) begin
      if (in_fire_q) sent++;
      drain_hold = (sent == 300 && expected_rsps.size() != 0);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !drain_hold) begin
        in_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls on its own pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase % 512) < 200 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict at input acceptance, compare at output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_rsps.insert(expected_rsps.size(), apply_event(in_req));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp);
        end else begin
          lobu_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== out_rsp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_rsp);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog and end of run
  initial begin
    wait (rst_n);
    while (!(pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    repeat (50) @(posedge clk);
    if (out_valid) mismatches++;
    if (!timed_out && mismatches == 0 && expected_rsps.size() == 0)
      $display("[limit_order_book_update] OK");
    else
      $display("[limit_order_book_update] ERROR");
    $finish;
  end

endmodule
